### design/cidb_pkg.sv
// ----------------------------------------------------------------------------
// cidb_pkg
// shared types and codes of the channel id bitmap allocator
// ----------------------------------------------------------------------------
package cidb_pkg;

	localparam int GRANT_W  = 11;
	localparam int TARGET_W = 12;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		ST_ALLOCATED = 2'd0,
		ST_FULL      = 2'd1,
		ST_FREED     = 2'd2,
		ST_IGNORED   = 2'd3
	} status_t;

	typedef struct packed {
		logic re;
		logic we;
	} mem_req_t;

	typedef struct packed {
		logic clear_chunk;
		logic next_chunk;
		logic upd;
		logic upd_full;
	} sum_ctl_t;

	typedef struct packed {
		logic hit;
		logic last;
	} sum_res_t;

endpackage

### design/cidb_bitmap_ram.sv
// ----------------------------------------------------------------------------
// cidb_bitmap_ram
// single port bitmap word memory, one read or write a cycle, registered read
// ----------------------------------------------------------------------------
module cidb_bitmap_ram import cidb_pkg::*; #(
	parameter int DEPTH  = 32,
	parameter int WIDTH  = 64,
	parameter int ADDR_W = 5
) (
	input  logic              clk,
	input  mem_req_t          req,
	input  logic [ADDR_W-1:0] addr,
	input  logic [WIDTH-1:0]  wdata,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[addr] <= wdata;
		end
		if (req.re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

### design/cidb_summary.sv
// ----------------------------------------------------------------------------
// cidb_summary
// one full flag per bitmap word, searched one chunk of flags per cycle
// ----------------------------------------------------------------------------
module cidb_summary import cidb_pkg::*; #(
	parameter int WORD_COUNT = 32,
	parameter int ADDR_W     = 5
) (
	input  logic              clk,
	input  logic              arst_n,
	input  sum_ctl_t          ctl,
	input  logic [ADDR_W-1:0] upd_addr,
	output sum_res_t          res,
	output logic [ADDR_W-1:0] hit_addr
);

	localparam int CH      = (WORD_COUNT < 32) ? WORD_COUNT : 32;
	localparam int NCH     = (WORD_COUNT + CH - 1) / CH;
	localparam int CHUNK_W = (NCH > 1) ? $clog2(NCH) : 1;
	localparam int POS_W   = (CH > 1) ? $clog2(CH) : 1;

	logic [WORD_COUNT-1:0] full_q;
	logic [NCH*CH-1:0]     full_pad;
	logic [CHUNK_W-1:0]    chunk_q;
	logic [CH-1:0]         slice;
	logic [POS_W-1:0]      pos;

	always_comb begin
		full_pad = '1;
		full_pad[WORD_COUNT-1:0] = full_q;
	end

	assign slice = full_pad[int'(chunk_q)*CH +: CH];

	// lowest word of the chunk that still has a clear bit
	always_comb begin
		pos = '0;
		for (int i = CH - 1; i >= 0; i--) begin
			if (!slice[i]) begin
				pos = POS_W'(i);
			end
		end
	end

	assign res.hit  = ~&slice;
	assign res.last = (chunk_q == CHUNK_W'(NCH - 1));
	assign hit_addr = ADDR_W'(int'(chunk_q) * CH + int'(pos));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q  <= '0;
			chunk_q <= '0;
		end else begin
			if (ctl.upd) begin
				full_q[upd_addr] <= ctl.upd_full;
			end
			if (ctl.clear_chunk) begin
				chunk_q <= '0;
			end else if (ctl.next_chunk) begin
				chunk_q <= chunk_q + 1'b1;
			end
		end
	end

endmodule

### design/channel_id_bitmap_allocator.sv
// ----------------------------------------------------------------------------
// channel_id_bitmap_allocator
// bitmap id allocator: lowest clear bit on allocate, clear named bit on free
// ----------------------------------------------------------------------------
// allocate: S_SEARCH steps through the 32-word chunks of the full-word summary
//   until a hit, then S_READ and S_RESP; pool full: S_SEARCH straight to S_RESP
// free: S_DIVQ, S_READ, S_RESP; out-of-range free: straight to S_RESP
// throughput: one item at a time, set by the read-modify-write of the word ram
// reset: full flags clear at once, then the word ram is swept one word a cycle
//   with req_stall high
module channel_id_bitmap_allocator import cidb_pkg::*; #(
	parameter int ID_COUNT  = 2048,
	parameter int WORD_BITS = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  logic                opcode,
	input  logic [TARGET_W-1:0] target_id,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output logic [GRANT_W-1:0]  granted_id,
	output logic [1:0]          status
);

	localparam int WORD_COUNT = (ID_COUNT + WORD_BITS - 1) / WORD_BITS;
	localparam int ADDR_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
	localparam int BIT_W      = $clog2(WORD_BITS);
	localparam int LAST_BITS  = ID_COUNT - (WORD_COUNT - 1) * WORD_BITS;
	localparam int DIV_K      = 24;
	localparam int DIV_M      = (1 << DIV_K) / WORD_BITS + 1;
	localparam logic [16:0] IDC17   = 17'(ID_COUNT);
	localparam logic [16:0] WB17    = 17'(WORD_BITS);
	localparam logic [39:0] DIV_M40 = 40'(DIV_M);
	localparam logic [WORD_BITS-1:0] LAST_MASK =
		{WORD_BITS{1'b1}} >> (WORD_BITS - LAST_BITS);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DIVQ,
		S_SEARCH,
		S_READ,
		S_RESP
	} state_t;

	state_t               state_q;
	logic [ADDR_W-1:0]    clr_q;
	logic                 op_q;
	logic [TARGET_W-1:0]  id_q;
	logic [ADDR_W-1:0]    word_q;
	logic [GRANT_W-1:0]   res_id_q;
	status_t              res_st_q;
	logic                 rsp_valid_q;
	logic [GRANT_W-1:0]   granted_q;
	status_t              status_q;

	mem_req_t             mem_req;
	logic [ADDR_W-1:0]    mem_addr;
	logic [WORD_BITS-1:0] mem_wdata;
	logic [WORD_BITS-1:0] mem_rdata;

	sum_ctl_t             sum_ctl;
	sum_res_t             sum_res;
	logic [ADDR_W-1:0]    hit_addr;

	logic [39:0]          quot_prod;
	logic [ADDR_W-1:0]    quot;
	logic [WORD_BITS-1:0] valid_mask;
	logic [WORD_BITS-1:0] eff_word;
	logic [BIT_W-1:0]     free_pos;
	logic [BIT_W-1:0]     clr_bit;
	logic [16:0]          clr_bit17;
	logic [WORD_BITS-1:0] new_word;
	logic [16:0]          grant17;
	logic                 accept;

	assign accept = req_valid && !req_stall;
	assign req_stall = (state_q != S_IDLE);

	// word index of a free item by reciprocal multiply
	assign quot_prod = 40'(id_q) * DIV_M40;
	assign quot      = quot_prod[DIV_K +: ADDR_W];

	assign valid_mask = (word_q == ADDR_W'(WORD_COUNT - 1)) ? LAST_MASK : '1;
	assign eff_word   = mem_rdata | ~valid_mask;

	always_comb begin
		free_pos = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (!eff_word[i]) begin
				free_pos = BIT_W'(i);
			end
		end
	end

	assign clr_bit17 = 17'(id_q) - 17'(word_q) * WB17;
	assign clr_bit   = clr_bit17[BIT_W-1:0];
	assign new_word  = (op_q == OP_ALLOC)
		? (mem_rdata | (WORD_BITS'(1) << free_pos))
		: (mem_rdata & ~(WORD_BITS'(1) << clr_bit));
	assign grant17   = 17'(word_q) * WB17 + 17'(free_pos);

	always_comb begin
		mem_req   = '0;
		mem_addr  = word_q;
		mem_wdata = new_word;
		sum_ctl   = '0;
		sum_ctl.upd_full = &(new_word | ~valid_mask);
		case (state_q)
			S_CLEAR: begin
				mem_req.we = 1'b1;
				mem_addr   = clr_q;
				mem_wdata  = (clr_q == '0) ? WORD_BITS'(1) : '0;
			end
			S_DIVQ: begin
				mem_req.re = 1'b1;
				mem_addr   = quot;
			end
			S_SEARCH: begin
				mem_req.re = sum_res.hit;
				mem_addr   = hit_addr;
				sum_ctl.clear_chunk = sum_res.hit || sum_res.last;
				sum_ctl.next_chunk  = !sum_res.hit && !sum_res.last;
			end
			S_READ: begin
				mem_req.we  = 1'b1;
				sum_ctl.upd = 1'b1;
			end
			default: begin
			end
		endcase
	end

	cidb_bitmap_ram #(
		.DEPTH  (WORD_COUNT),
		.WIDTH  (WORD_BITS),
		.ADDR_W (ADDR_W)
	) u_ram (
		.clk   (clk),
		.req   (mem_req),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	cidb_summary #(
		.WORD_COUNT (WORD_COUNT),
		.ADDR_W     (ADDR_W)
	) u_summary (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (sum_ctl),
		.upd_addr (word_q),
		.res      (sum_res),
		.hit_addr (hit_addr)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			op_q        <= OP_ALLOC;
			id_q        <= '0;
			word_q      <= '0;
			res_id_q    <= '0;
			res_st_q    <= ST_ALLOCATED;
			rsp_valid_q <= 1'b0;
			granted_q   <= '0;
			status_q    <= ST_ALLOCATED;
		end else begin
			if (rsp_valid_q && !rsp_stall && state_q != S_RESP) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ADDR_W'(WORD_COUNT - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						op_q     <= opcode;
						id_q     <= target_id;
						res_id_q <= '0;
						if (opcode == OP_ALLOC) begin
							state_q <= S_SEARCH;
						end else if (17'(target_id) >= IDC17) begin
							res_st_q <= ST_IGNORED;
							state_q  <= S_RESP;
						end else begin
							state_q <= S_DIVQ;
						end
					end
				end
				S_DIVQ: begin
					word_q  <= quot;
					state_q <= S_READ;
				end
				S_SEARCH: begin
					if (sum_res.hit) begin
						word_q  <= hit_addr;
						state_q <= S_READ;
					end else if (sum_res.last) begin
						res_st_q <= ST_FULL;
						state_q  <= S_RESP;
					end
				end
				S_READ: begin
					if (op_q == OP_ALLOC) begin
						res_id_q <= grant17[GRANT_W-1:0];
						res_st_q <= ST_ALLOCATED;
					end else begin
						res_st_q <= ST_FREED;
					end
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_valid_q <= 1'b1;
						granted_q   <= res_id_q;
						status_q    <= res_st_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign granted_id = granted_q;
	assign status     = status_q;

`ifndef ASSERT_OFF
	a_ram_single_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_req.re && mem_req.we))
		else $error("word ram read and written in one cycle");

	a_read_after_issue: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ) |-> $past(mem_req.re))
		else $error("modify step without a word read");

	a_rsp_from_resp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(state_q == S_RESP))
		else $error("result appeared outside the response step");

	a_full_no_id: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && status == ST_FULL) |-> (granted_id == '0))
		else $error("pool full item carries an id");
`endif

endmodule
